>>> src/tvs_pkg.sv
// ----------------------------------------------------------------------------
// tvs_pkg
// Shared types and constants of the trilinear volume sampler.
// ----------------------------------------------------------------------------
package tvs_pkg;

   localparam int AXIS_BITS   = 5;
   localparam int SIZE_BITS   = 6;
   localparam int FRAC_BITS   = 8;
   localparam int VALUE_BITS  = 16;
   localparam int LOC_BITS    = 18;
   localparam int INV_BITS    = 16;
   localparam int PROD_BITS   = LOC_BITS + INV_BITS + 1;
   localparam int PROD_FRAC   = 20;
   localparam int ADDR_BITS   = 1 + 3 * AXIS_BITS;
   localparam int WEIGHT_BITS = FRAC_BITS + 1;
   localparam int CSR_IDX_BITS = 3;

   localparam logic [CSR_IDX_BITS-1:0] CSR_SIZE_X     = 3'd0;
   localparam logic [CSR_IDX_BITS-1:0] CSR_SIZE_Y     = 3'd1;
   localparam logic [CSR_IDX_BITS-1:0] CSR_SIZE_Z     = 3'd2;
   localparam logic [CSR_IDX_BITS-1:0] CSR_INV_RES_X  = 3'd3;
   localparam logic [CSR_IDX_BITS-1:0] CSR_INV_RES_Y  = 3'd4;
   localparam logic [CSR_IDX_BITS-1:0] CSR_INV_RES_Z  = 3'd5;
   localparam logic [CSR_IDX_BITS-1:0] CSR_BACKGROUND = 3'd6;

   localparam logic REQ_WRITE  = 1'b0;
   localparam logic REQ_SAMPLE = 1'b1;

   typedef struct packed {
      logic [SIZE_BITS-1:0]  size_x;   // already saturated to 1..32
      logic [SIZE_BITS-1:0]  size_y;
      logic [SIZE_BITS-1:0]  size_z;
      logic [INV_BITS-1:0]   inv_x;
      logic [INV_BITS-1:0]   inv_y;
      logic [INV_BITS-1:0]   inv_z;
      logic [VALUE_BITS-1:0] background;
   } cfg_type;

   // One classified request as it travels from the front to the back.
   typedef struct packed {
      logic                  is_sample;
      logic                  outside;
      logic                  rank;
      logic [AXIS_BITS-1:0]  x;        // write index or integer coordinate
      logic [AXIS_BITS-1:0]  y;
      logic [AXIS_BITS-1:0]  z;
      logic [FRAC_BITS-1:0]  fr_x;
      logic [FRAC_BITS-1:0]  fr_y;
      logic [FRAC_BITS-1:0]  fr_z;
      logic [VALUE_BITS-1:0] value;
   } job_type;

endpackage

>>> src/trilinear_volume_sampler_top.sv
// ----------------------------------------------------------------------------
// trilinear_volume_sampler_top
// Voxel volume store with trilinear sampling.
// ----------------------------------------------------------------------------
// Requests arrive on req_*: tuser selects a voxel write (0) or a sample (1).
// A write stores one 16-bit voxel of a rank and gives no response. A sample
// gives one response on rsp_*: the interpolated value in tdata and, in tuser,
// a flag set when the location lay outside the volume (tdata then carries
// the background register).
// A request passes a front register, a two-entry job queue and the back end.
// A write reaches the memory through the front register and the queue; the
// back end takes one write per cycle while it is idle. An inside sample
// visits the single memory read port once for each of the eight neighbours,
// and each neighbour passes S_RD, S_W, S_MUL and S_ACC of the weight and
// multiply path; no new job is taken until the sample's response is loaded.
// An outside sample goes from S_IDLE straight to S_DONE. Registers are to be
// written over csr_* only while the block is idle, which the block does not
// enforce; csr_ready is always high. Reset restores the register defaults and
// empties the queue; the voxel memory is not cleared and must be written
// before it is read. A stalled response waits in its output register; the
// front end and queue keep taking requests until the queue fills.
// ----------------------------------------------------------------------------
module trilinear_volume_sampler_top import tvs_pkg::*; (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_tvalid,
   output logic                      req_tready,
   // voxel_x[4:0] voxel_y[9:5] voxel_z[14:10] rank[15] voxel_value[31:16]
   // loc_x[49:32] loc_y[67:50] loc_z[85:68], zero fill above
   input  logic [87:0]               req_tdata,
   // req_type[0]
   input  logic                      req_tuser,
   output logic                      rsp_tvalid,
   input  logic                      rsp_tready,
   // sample_value[15:0]
   output logic [15:0]               rsp_tdata,
   // used_background[0]
   output logic                      rsp_tuser,
   input  logic                      csr_valid,
   output logic                      csr_ready,
   input  logic [CSR_IDX_BITS-1:0]   csr_index,
   input  logic [15:0]               csr_data
);

   logic [SIZE_BITS-1:0]  size_x_ff, size_y_ff, size_z_ff;
   logic [INV_BITS-1:0]   inv_x_ff, inv_y_ff, inv_z_ff;
   logic [VALUE_BITS-1:0] bg_ff;
   cfg_type               cfg;
   logic                  q_in_valid, q_in_ready, q_out_valid, q_out_ready;
   job_type               q_in_job, q_out_job;

   function automatic logic [SIZE_BITS-1:0] sat_size(input logic [SIZE_BITS-1:0] s);
      if (s == '0) begin
         return SIZE_BITS'(1);
      end else if (s > SIZE_BITS'(32)) begin
         return SIZE_BITS'(32);
      end
      return s;
   endfunction

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         size_x_ff <= SIZE_BITS'(32);
         size_y_ff <= SIZE_BITS'(32);
         size_z_ff <= SIZE_BITS'(32);
         inv_x_ff  <= INV_BITS'(4096);
         inv_y_ff  <= INV_BITS'(4096);
         inv_z_ff  <= INV_BITS'(4096);
         bg_ff     <= '0;
      end else if (csr_valid) begin
         case (csr_index)
            CSR_SIZE_X:     size_x_ff <= csr_data[SIZE_BITS-1:0];
            CSR_SIZE_Y:     size_y_ff <= csr_data[SIZE_BITS-1:0];
            CSR_SIZE_Z:     size_z_ff <= csr_data[SIZE_BITS-1:0];
            CSR_INV_RES_X:  inv_x_ff  <= csr_data;
            CSR_INV_RES_Y:  inv_y_ff  <= csr_data;
            CSR_INV_RES_Z:  inv_z_ff  <= csr_data;
            CSR_BACKGROUND: bg_ff     <= csr_data;
            default: ;
         endcase
      end
   end

   always_comb begin
      cfg.size_x     = sat_size(size_x_ff);
      cfg.size_y     = sat_size(size_y_ff);
      cfg.size_z     = sat_size(size_z_ff);
      cfg.inv_x      = inv_x_ff;
      cfg.inv_y      = inv_y_ff;
      cfg.inv_z      = inv_z_ff;
      cfg.background = bg_ff;
   end

   tvs_front u_front (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg),
      .in_valid  (req_tvalid),
      .in_ready  (req_tready),
      .in_type   (req_tuser),
      .in_x      (req_tdata[4:0]),
      .in_y      (req_tdata[9:5]),
      .in_z      (req_tdata[14:10]),
      .in_rank   (req_tdata[15]),
      .in_value  (req_tdata[31:16]),
      .in_loc_x  (req_tdata[49:32]),
      .in_loc_y  (req_tdata[67:50]),
      .in_loc_z  (req_tdata[85:68]),
      .job_valid (q_in_valid),
      .job_ready (q_in_ready),
      .job       (q_in_job)
   );

   tvs_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (q_in_valid),
      .push_ready (q_in_ready),
      .push_job   (q_in_job),
      .pop_valid  (q_out_valid),
      .pop_ready  (q_out_ready),
      .pop_job    (q_out_job)
   );

   tvs_back u_back (
      .clock          (clock),
      .reset          (reset),
      .cfg            (cfg),
      .job_valid      (q_out_valid),
      .job_ready      (q_out_ready),
      .job            (q_out_job),
      .rsp_valid      (rsp_tvalid),
      .rsp_ready      (rsp_tready),
      .rsp_value      (rsp_tdata),
      .rsp_background (rsp_tuser)
   );

endmodule

>>> src/tvs_front.sv
// ----------------------------------------------------------------------------
// tvs_front
// Registers a request, scales the location into voxel coordinates and
// classifies it into a job for the back end.
// ----------------------------------------------------------------------------
module tvs_front import tvs_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   input  cfg_type               cfg,
   input  logic                  in_valid,
   output logic                  in_ready,
   input  logic                  in_type,
   input  logic [AXIS_BITS-1:0]  in_x,
   input  logic [AXIS_BITS-1:0]  in_y,
   input  logic [AXIS_BITS-1:0]  in_z,
   input  logic                  in_rank,
   input  logic [VALUE_BITS-1:0] in_value,
   input  logic [LOC_BITS-1:0]   in_loc_x,
   input  logic [LOC_BITS-1:0]   in_loc_y,
   input  logic [LOC_BITS-1:0]   in_loc_z,
   output logic                  job_valid,
   input  logic                  job_ready,
   output job_type               job
);

   logic                  valid_ff, valid_in;
   logic                  type_ff, rank_ff;
   logic [AXIS_BITS-1:0]  x_ff, y_ff, z_ff;
   logic [VALUE_BITS-1:0] value_ff;
   logic [LOC_BITS-1:0]   lx_ff, ly_ff, lz_ff;
   logic [PROD_BITS-1:0]  px, py, pz;
   logic                  out_x, out_y, out_z;

   function automatic logic [PROD_BITS-1:0] scale(input logic [LOC_BITS-1:0] loc,
                                                  input logic [INV_BITS-1:0] inv);
      logic signed [PROD_BITS-1:0] loc_s;
      logic signed [PROD_BITS-1:0] inv_s;
      loc_s = PROD_BITS'($signed(loc));
      inv_s = PROD_BITS'($signed({1'b0, inv}));
      return loc_s * inv_s;
   endfunction

   function automatic logic beyond(input logic [PROD_BITS-1:0] p,
                                   input logic [SIZE_BITS-1:0] size);
      logic [SIZE_BITS-1:0] lim;
      lim = size - SIZE_BITS'(1);
      return p[PROD_BITS-1] ||
             (p[PROD_BITS-2:0] > (PROD_BITS-1)'({lim, {PROD_FRAC{1'b0}}}));
   endfunction

   assign in_ready  = !valid_ff || job_ready;
   assign job_valid = valid_ff;
   assign valid_in  = in_ready ? in_valid : valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (in_ready && in_valid) begin
         type_ff  <= in_type;
         rank_ff  <= in_rank;
         x_ff     <= in_x;
         y_ff     <= in_y;
         z_ff     <= in_z;
         value_ff <= in_value;
         lx_ff    <= in_loc_x;
         ly_ff    <= in_loc_y;
         lz_ff    <= in_loc_z;
      end
   end

   assign px    = scale(lx_ff, cfg.inv_x);
   assign py    = scale(ly_ff, cfg.inv_y);
   assign pz    = scale(lz_ff, cfg.inv_z);
   assign out_x = beyond(px, cfg.size_x);
   assign out_y = beyond(py, cfg.size_y);
   assign out_z = beyond(pz, cfg.size_z);

   // Inside the volume the integer part is below 32, so five bits hold it.
   always_comb begin
      job           = '0;
      job.is_sample = (type_ff == REQ_SAMPLE);
      job.rank      = rank_ff;
      job.value     = value_ff;
      if (type_ff == REQ_SAMPLE) begin
         job.outside = out_x || out_y || out_z;
         job.x       = px[PROD_FRAC+AXIS_BITS-1:PROD_FRAC];
         job.y       = py[PROD_FRAC+AXIS_BITS-1:PROD_FRAC];
         job.z       = pz[PROD_FRAC+AXIS_BITS-1:PROD_FRAC];
         job.fr_x    = px[PROD_FRAC-1:PROD_FRAC-FRAC_BITS];
         job.fr_y    = py[PROD_FRAC-1:PROD_FRAC-FRAC_BITS];
         job.fr_z    = pz[PROD_FRAC-1:PROD_FRAC-FRAC_BITS];
      end else begin
         job.x = x_ff;
         job.y = y_ff;
         job.z = z_ff;
      end
   end

endmodule

>>> src/tvs_queue.sv
// ----------------------------------------------------------------------------
// tvs_queue
// Two-entry job queue between the front end and the back end.
// ----------------------------------------------------------------------------
module tvs_queue import tvs_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    push_valid,
   output logic    push_ready,
   input  job_type push_job,
   output logic    pop_valid,
   input  logic    pop_ready,
   output job_type pop_job
);

   job_type     entry_ff [2];
   logic        wr_ptr_ff, wr_ptr_in;
   logic        rd_ptr_ff, rd_ptr_in;
   logic [1:0]  count_ff, count_in;
   logic        push, pop;

   assign push_ready = (count_ff != 2'd2);
   assign pop_valid  = (count_ff != 2'd0);
   assign pop_job    = entry_ff[rd_ptr_ff];
   assign push       = push_valid && push_ready;
   assign pop        = pop_valid && pop_ready;

   always_comb begin
      wr_ptr_in = wr_ptr_ff ^ push;
      rd_ptr_in = rd_ptr_ff ^ pop;
      count_in  = count_ff + 2'(push) - 2'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_job;
      end
   end

endmodule

>>> src/tvs_back.sv
// ----------------------------------------------------------------------------
// tvs_back
// Holds the voxel memory, performs writes and walks the eight neighbours of
// a sample through a shared weight and multiply path.
// ----------------------------------------------------------------------------
module tvs_back import tvs_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   input  cfg_type               cfg,
   input  logic                  job_valid,
   output logic                  job_ready,
   input  job_type               job,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output logic [VALUE_BITS-1:0] rsp_value,
   output logic                  rsp_background
);

   typedef enum logic [5:0] {
      S_IDLE = 6'b000001,
      S_RD   = 6'b000010,
      S_W    = 6'b000100,
      S_MUL  = 6'b001000,
      S_ACC  = 6'b010000,
      S_DONE = 6'b100000
   } state_type;

   localparam int SUM_BITS  = VALUE_BITS + 2;
   localparam int W2_BITS   = 2 * WEIGHT_BITS;
   localparam int W3_BITS   = 3 * FRAC_BITS + 1;
   localparam int PROD_W    = W3_BITS + VALUE_BITS;
   localparam logic [WEIGHT_BITS-1:0] ONE_W = WEIGHT_BITS'(1) << FRAC_BITS;

   logic [VALUE_BITS-1:0] mem [2**ADDR_BITS];
   logic [VALUE_BITS-1:0] rd_data_ff;
   logic [ADDR_BITS-1:0]  rd_addr;

   state_type             state_ff, state_in;
   job_type               job_ff;
   logic [2:0]            k_ff, k_in;
   logic [SUM_BITS-1:0]   sum_ff, sum_in;
   logic [W2_BITS-1:0]    wxy_ff;
   logic [WEIGHT_BITS-1:0] wz_ff;
   logic                  skip_ff, skip_st_ff;
   logic [W3_BITS-1:0]    w_ff;
   logic [VALUE_BITS-1:0] val_ff;
   logic [VALUE_BITS-1:0] term_ff;
   logic                  rsp_valid_ff, rsp_valid_in;
   logic [VALUE_BITS-1:0] rsp_value_ff;
   logic                  rsp_bg_ff;
   logic                  load_rsp;

   logic [SIZE_BITS-1:0]   ix, iy, iz;
   logic [WEIGHT_BITS-1:0] wx, wy, wz;
   logic                   skip;

   // Neighbour index and weights for corner k; bit 0 of k picks x+1.
   always_comb begin
      ix   = {1'b0, job_ff.x} + SIZE_BITS'(k_ff[0]);
      iy   = {1'b0, job_ff.y} + SIZE_BITS'(k_ff[1]);
      iz   = {1'b0, job_ff.z} + SIZE_BITS'(k_ff[2]);
      wx   = k_ff[0] ? WEIGHT_BITS'(job_ff.fr_x) : ONE_W - WEIGHT_BITS'(job_ff.fr_x);
      wy   = k_ff[1] ? WEIGHT_BITS'(job_ff.fr_y) : ONE_W - WEIGHT_BITS'(job_ff.fr_y);
      wz   = k_ff[2] ? WEIGHT_BITS'(job_ff.fr_z) : ONE_W - WEIGHT_BITS'(job_ff.fr_z);
      skip = (ix >= cfg.size_x) || (iy >= cfg.size_y) || (iz >= cfg.size_z);
      rd_addr = {job_ff.rank, iz[AXIS_BITS-1:0], iy[AXIS_BITS-1:0], ix[AXIS_BITS-1:0]};
   end

   assign job_ready = (state_ff == S_IDLE);
   assign load_rsp  = (state_ff == S_DONE) && (!rsp_valid_ff || rsp_ready);

   always_ff @(posedge clock) begin
      if (job_valid && (state_ff == S_IDLE) && !job.is_sample) begin
         mem[{job.rank, job.z, job.y, job.x}] <= job.value;
      end
      rd_data_ff <= mem[rd_addr];
   end

   always_comb begin
      state_in     = state_ff;
      k_in         = k_ff;
      sum_in       = sum_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      case (state_ff)
         S_IDLE: begin
            if (job_valid && job.is_sample) begin
               k_in     = 3'd0;
               sum_in   = '0;
               state_in = job.outside ? S_DONE : S_RD;
            end
         end
         S_RD:  state_in = S_W;
         S_W:   state_in = S_MUL;
         S_MUL: state_in = S_ACC;
         S_ACC: begin
            sum_in   = sum_ff + SUM_BITS'(term_ff);
            k_in     = k_ff + 3'd1;
            state_in = (k_ff == 3'd7) ? S_DONE : S_RD;
         end
         S_DONE: begin
            if (load_rsp) begin
               rsp_valid_in = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      k_ff   <= k_in;
      sum_ff <= sum_in;
      if (job_valid && (state_ff == S_IDLE)) begin
         job_ff <= job;
      end
      if (state_ff == S_RD) begin
         wxy_ff  <= wx * wy;
         wz_ff   <= wz;
         skip_ff <= skip;
      end
      if (state_ff == S_W) begin
         w_ff       <= W3_BITS'(wxy_ff) * W3_BITS'(wz_ff);
         val_ff     <= rd_data_ff;
         skip_st_ff <= skip_ff;
      end
      if (state_ff == S_MUL) begin
         // A neighbour past the upper edge adds nothing, whatever the memory held.
         term_ff <= skip_st_ff ? '0 :
                    VALUE_BITS'((PROD_W'(w_ff) * PROD_W'(val_ff)) >> (3 * FRAC_BITS));
      end
      if (load_rsp) begin
         rsp_value_ff <= job_ff.outside ? cfg.background : sum_ff[VALUE_BITS-1:0];
         rsp_bg_ff    <= job_ff.outside;
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_value      = rsp_value_ff;
   assign rsp_background = rsp_bg_ff;

endmodule

>>> tb/sv/tb_trilinear_volume_sampler_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_trilinear_volume_sampler_top
// Self-checking bench for the voxel store with trilinear sampling.
// Voxel writes and sample requests stream in with random gaps. Responses
// are drained under random back-pressure. A scoreboard keeps its own copy
// of the volume and the registers and predicts every sample response.
// ----------------------------------------------------------------------------
module tb_trilinear_volume_sampler_top;
   import tvs_pkg::*;

   typedef struct {
      logic [15:0] value;
      logic        outside;
   } sample_result_type;

   class volume_scoreboard;
      logic [VALUE_BITS-1:0] volume [0:65535];
      int unsigned size_v [3];
      int unsigned inv_v [3];
      logic [15:0] background;
      sample_result_type pending_q [$];
      int unsigned mismatches;

      function new();
         size_v = '{32, 32, 32};
         inv_v = '{4096, 4096, 4096};
         background = '0;
         mismatches = 0;
      endfunction

      function void set_reg(logic [CSR_IDX_BITS-1:0] idx, logic [15:0] data);
         case (idx)
            CSR_SIZE_X: size_v[0] = sat_size(data[5:0]);
            CSR_SIZE_Y: size_v[1] = sat_size(data[5:0]);
            CSR_SIZE_Z: size_v[2] = sat_size(data[5:0]);
            CSR_INV_RES_X: inv_v[0] = 32'(data);
            CSR_INV_RES_Y: inv_v[1] = 32'(data);
            CSR_INV_RES_Z: inv_v[2] = 32'(data);
            CSR_BACKGROUND: background = data;
            default: ;
         endcase
      endfunction

      function int unsigned sat_size(logic [5:0] s);
         if (s == 0) return 1;
         if (s > 32) return 32;
         return 32'(s);
      endfunction

      // Notes one accepted request and queues the response it should cause.
      function void note_request(logic kind, logic [87:0] d);
         logic signed [17:0] loc;
         longint prod;
         longint c;
         longint w;
         longint sum;
         int unsigned ip [3];
         int unsigned fr [3];
         int unsigned idx [3];
         bit outside;
         bit skip;
         bit hi;
         sample_result_type res;
         if (kind == REQ_WRITE) begin
            volume[{d[15], d[14:10], d[9:5], d[4:0]}] = d[31:16];
            return;
         end
         outside = 0;
         for (int a = 0; a < 3; a++) begin
            loc = d[32 + 18*a +: 18];
            prod = longint'(loc) * longint'(inv_v[a]);
            if (prod < 0 || prod > (longint'(size_v[a] - 1) <<< PROD_FRAC)) begin
               outside = 1;
               ip[a] = 0;
               fr[a] = 0;
            end else begin
               c = prod >>> (PROD_FRAC - FRAC_BITS);
               ip[a] = 32'(c >> FRAC_BITS);
               fr[a] = 32'(c & ((1 << FRAC_BITS) - 1));
            end
         end
         if (outside) begin
            res.value = background;
            res.outside = 1;
         end else begin
            sum = 0;
            for (int k = 0; k < 8; k++) begin
               w = 1;
               skip = 0;
               for (int a = 0; a < 3; a++) begin
                  hi = k[a];
                  idx[a] = ip[a] + hi;
                  if (idx[a] >= size_v[a]) skip = 1;
                  else w = w * (hi ? fr[a] : ((1 << FRAC_BITS) - fr[a]));
               end
               if (!skip)
                  sum += (w * longint'(volume[{d[15], idx[2][4:0], idx[1][4:0],
                                              idx[0][4:0]}])) >> (3 * FRAC_BITS);
            end
            res.value = sum[15:0];
            res.outside = 0;
         end
         pending_q.push_back(res);
      endfunction

      function void check_response(logic [15:0] value, logic flag);
         sample_result_type exp_r;
         if (pending_q.size() == 0) begin
            $error("response with nothing expected: sample_value=%h", value);
            mismatches++;
            return;
         end
         exp_r = pending_q.pop_front();
         if (value !== exp_r.value) begin
            $error("sample_value: expected %h, got %h", exp_r.value, value);
            mismatches++;
         end
         if (flag !== exp_r.outside) begin
            $error("used_background: expected %b, got %b", exp_r.outside, flag);
            mismatches++;
         end
      endfunction
   endclass

   logic clock = 0;
   logic reset = 1;
   logic req_tvalid = 0;
   logic req_tready;
   logic [87:0] req_tdata = '0;
   logic req_tuser = 0;
   logic rsp_tvalid;
   logic rsp_tready = 0;
   logic [15:0] rsp_tdata;
   logic rsp_tuser;
   logic csr_valid = 0;
   logic csr_ready;
   logic [CSR_IDX_BITS-1:0] csr_index = '0;
   logic [15:0] csr_data = '0;

   trilinear_volume_sampler_top dut (.*);

   always #1 clock = ~clock;

   volume_scoreboard board = new();
   bit written [0:65535];
   int unsigned cur_size [3];
   int unsigned cur_inv [3];
   int unsigned hold_cycles = 0;
   int unsigned idle_cycles = 0;

   always @(posedge clock) begin
      if (!reset) begin
         if (req_tvalid && req_tready) board.note_request(req_tuser, req_tdata);
         if (rsp_tvalid && rsp_tready) board.check_response(rsp_tdata, rsp_tuser);
         if (csr_valid && csr_ready) board.set_reg(csr_index, csr_data);
         if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)
             || (csr_valid && csr_ready))
            idle_cycles = 0;
         else
            idle_cycles++;
         if (idle_cycles >= 3000) begin
            $display("end of test: mismatches");
            $finish;
         end
      end
   end

   function int unsigned pick_gap();
      int unsigned r;
      r = $urandom_range(0, 99);
      if (r < 55) return 0;
      if (r < 92) return $urandom_range(1, 3);
      return $urandom_range(8, 40);
   endfunction

   // Receiver: random stalls, plus one long hold-off requested by the stimulus.
   initial begin
      int unsigned stall;
      stall = 0;
      forever begin
         @(negedge clock);
         if (hold_cycles > 0) begin
            rsp_tready = 0;
            hold_cycles--;
         end else if (stall > 0) begin
            rsp_tready = 0;
            stall--;
         end else begin
            rsp_tready = 1;
            if ($urandom_range(0, 3) == 0) stall = pick_gap();
         end
      end
   end

   task automatic send_req(logic kind, logic [87:0] d);
      int unsigned g;
      g = pick_gap();
      if (g > 0) begin
         req_tvalid = 0;
         repeat (g) @(negedge clock);
      end
      req_tvalid = 1;
      req_tuser = kind;
      req_tdata = d;
      do @(posedge clock); while (!req_tready);
      @(negedge clock);
   endtask

   task automatic send_write(logic r, int unsigned x, int unsigned y, int unsigned z,
                             logic [15:0] v);
      written[{r, z[4:0], y[4:0], x[4:0]}] = 1;
      send_req(REQ_WRITE, {56'd0, v, r, z[4:0], y[4:0], x[4:0]});
   endtask

   // Loads every neighbour a sample may read that was never written, then samples.
   task automatic send_sample(logic r, logic [17:0] lx, logic [17:0] ly, logic [17:0] lz);
      logic [17:0] locs [3];
      longint prod;
      int unsigned ip [3];
      int unsigned n [3];
      bit in_volume;
      locs = '{lx, ly, lz};
      in_volume = 1;
      for (int a = 0; a < 3; a++) begin
         prod = longint'($signed(locs[a])) * longint'(cur_inv[a]);
         if (prod < 0 || prod > (longint'(cur_size[a] - 1) <<< PROD_FRAC)) in_volume = 0;
         else ip[a] = 32'(prod >>> PROD_FRAC);
      end
      if (in_volume) begin
         for (int k = 0; k < 8; k++) begin
            for (int a = 0; a < 3; a++) n[a] = ip[a] + ((k >> a) & 1);
            if (n[0] < 32 && n[1] < 32 && n[2] < 32
                && !written[{r, n[2][4:0], n[1][4:0], n[0][4:0]}])
               send_write(r, n[0], n[1], n[2], 16'($urandom));
         end
      end
      send_req(REQ_SAMPLE, {2'b0, lz, ly, lx, 16'd0, r, 15'd0});
   endtask

   task automatic write_csr(logic [CSR_IDX_BITS-1:0] idx, logic [15:0] data);
      csr_valid = 1;
      csr_index = idx;
      csr_data = data;
      do @(posedge clock); while (!csr_ready);
      @(negedge clock);
      csr_valid = 0;
   endtask

   task automatic set_config(int unsigned sx, int unsigned sy, int unsigned sz,
                             int unsigned ix, int unsigned iy, int unsigned iz,
                             logic [15:0] bg);
      cur_size = '{sx, sy, sz};
      cur_inv = '{ix, iy, iz};
      write_csr(CSR_SIZE_X, 16'(sx));
      write_csr(CSR_SIZE_Y, 16'(sy));
      write_csr(CSR_SIZE_Z, 16'(sz));
      write_csr(CSR_INV_RES_X, 16'(ix));
      write_csr(CSR_INV_RES_Y, 16'(iy));
      write_csr(CSR_INV_RES_Z, 16'(iz));
      write_csr(CSR_BACKGROUND, bg);
   endtask

   // Location near the used range of one axis, edges included.
   function automatic logic [17:0] near_loc(int a);
      longint maxl;
      longint lo;
      longint hi;
      longint pick;
      maxl = (longint'(cur_size[a] - 1) <<< PROD_FRAC) / cur_inv[a];
      if ($urandom_range(0, 9) < 2) begin
         pick = maxl + $urandom_range(0, 1);
      end else begin
         lo = -(maxl / 8) - 2;
         hi = maxl + maxl / 8 + 2;
         if (lo < -131072) lo = -131072;
         if (hi > 131071) hi = 131071;
         pick = lo + $urandom_range(0, int'(hi - lo));
      end
      if (pick > 131071) pick = 131071;
      return pick[17:0];
   endfunction

   task automatic random_phase(int unsigned count);
      int unsigned r;
      for (int i = 0; i < count; i++) begin
         r = $urandom_range(0, 99);
         if (r < 15)
            send_write(1'($urandom_range(0, 1)), $urandom_range(0, 31),
                       $urandom_range(0, 31), $urandom_range(0, 31), 16'($urandom));
         else if (r < 25)
            send_sample(1'($urandom_range(0, 1)), 18'($urandom), 18'($urandom),
                        18'($urandom));
         else
            send_sample(1'($urandom_range(0, 1)), near_loc(0), near_loc(1), near_loc(2));
      end
      req_tvalid = 0;
   endtask

   // Writes can leave the back end busy after the last response, so wait on.
   task automatic drain();
      while (board.pending_q.size() != 0) @(negedge clock);
      repeat (50) @(negedge clock);
   endtask

   initial begin
      repeat (6) @(posedge clock);
      @(negedge clock);
      reset = 0;
      set_config(32, 32, 32, 4096, 4096, 4096, 16'h0000);

      // Directed: value and location extremes, both ranks, exact upper edge.
      send_write(1'b0, 0, 0, 0, 16'h0000);
      send_write(1'b1, 31, 31, 31, 16'hFFFF);
      send_write(1'b1, 30, 30, 30, 16'hFFFF);
      send_sample(1'b0, 18'd0, 18'd0, 18'd0);
      send_sample(1'b1, 18'd7936, 18'd7936, 18'd7936);
      send_sample(1'b1, 18'd7680, 18'd7680, 18'd7680);
      send_sample(1'b1, 18'd7808, 18'd7900, 18'd7700);
      send_sample(1'b0, 18'd7937, 18'd0, 18'd0);
      send_sample(1'b0, 18'd0, -18'sd1, 18'd0);
      send_sample(1'b0, 18'd0, 18'd0, 18'h20000);
      send_sample(1'b1, 18'h1FFFF, 18'h1FFFF, 18'h1FFFF);
      send_sample(1'b0, 18'd128, 18'd64, 18'd200);
      send_write(1'b0, 5, 6, 7, 16'h8001);
      send_sample(1'b0, 18'd1300, 18'd1560, 18'd1800);
      req_tvalid = 0;

      // The receiver holds off while requests keep coming, so the input stalls.
      hold_cycles = 400;
      random_phase(120);
      drain();

      set_config(1, 1, 1, 65535, 65535, 65535, 16'hFFFF);
      random_phase(100);
      drain();

      set_config(32, 32, 32, 1, 1, 1, 16'h1234);
      random_phase(100);
      drain();

      set_config(2, 32, 5, 65535, 4096, 1, 16'h8000);
      random_phase(100);
      drain();

      for (int p = 0; p < 3; p++) begin
         set_config($urandom_range(1, 32), $urandom_range(1, 32), $urandom_range(1, 32),
                    $urandom_range(256, 16384), $urandom_range(256, 16384),
                    $urandom_range(1, 65535), 16'($urandom));
         random_phase(80);
         drain();
      end

      if (board.mismatches == 0 && board.pending_q.size() == 0) begin
         $display("end of test: clean");
      end else begin
         if (board.pending_q.size() != 0)
            $error("%0d responses never arrived", board.pending_q.size());
         $display("end of test: mismatches");
      end
      $finish;
   end

endmodule
